>>> hdl/gaead_pkg.sv
package gaead_pkg;

   localparam logic [2:0] OP_START   = 3'd0;
   localparam logic [2:0] OP_AUTH    = 3'd1;
   localparam logic [2:0] OP_ENCRYPT = 3'd2;
   localparam logic [2:0] OP_DECRYPT = 3'd3;
   localparam logic [2:0] OP_FINISH  = 3'd4;

   localparam logic [1:0] CSR_KEY_UPPER   = 2'd0;
   localparam logic [1:0] CSR_KEY_LOWER   = 2'd1;
   localparam logic [1:0] CSR_NONCE_UPPER = 2'd2;
   localparam logic [1:0] CSR_NONCE_LOWER = 2'd3;

   localparam logic [31:0] PAD_WORD = 32'hFFFFFFFE;

   typedef struct packed {
      logic [2:0] operation;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic [63:0] tag_value;
      logic        tag_ready;
   } rsp_type;

   // control from sequencer to the round unit
   typedef struct packed {
      logic        load;
      logic        step;
      logic [1:0]  mode;
      logic [31:0] lin_extra;
   } round_ctl_type;

   localparam logic [1:0] FB_NONE = 2'd0;
   localparam logic [1:0] FB_BOTH = 2'd1;
   localparam logic [1:0] FB_LIN  = 2'd2;

   // 32 bits of a:b starting at bit n, msb first
   function automatic logic [31:0] win(input logic [31:0] a, input logic [31:0] b,
                                       input int n);
      logic [63:0] ab;
      ab = {a, b};
      return ab[63-n -: 32];
   endfunction

   function automatic logic [31:0] rev_bytes32(input logic [31:0] v);
      logic [31:0] r;
      for (int i = 0; i < 4; i++)
         for (int j = 0; j < 8; j++)
            r[8*i+j] = v[8*i+7-j];
      return r;
   endfunction

   function automatic logic [31:0] swap_step(input logic [31:0] v, input logic [31:0] m,
                                             input int s);
      logic [31:0] t;
      t = ((v >> s) ^ v) & m;
      return v ^ t ^ (t << s);
   endfunction

   // keystream word into even/odd byte order
   function automatic logic [31:0] interleave(input logic [31:0] v);
      logic [31:0] x;
      x = swap_step(v, 32'h11111111, 3);
      x = swap_step(x, 32'h03030303, 6);
      x = swap_step(x, 32'h000f000f, 12);
      return ((x & 32'h00ff00ff) << 8) | ((x >> 8) & 32'h00ff00ff);
   endfunction

endpackage

>>> hdl/gaead_round.sv
module gaead_round
   import gaead_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  round_ctl_type  ctl,
   input  logic [127:0]   load_lin,
   input  logic [127:0]   load_nl,
   output logic [31:0]    pre_word
);

   logic [31:0] s_ff [4];
   logic [31:0] b_ff [4];
   logic [31:0] s_fb, b_fb, x0, x4;

   // pre-output word
   always_comb begin
      x0 = win(b_ff[0], b_ff[1], 12);
      x4 = win(b_ff[2], b_ff[3], 31);
      pre_word = (x0 & win(s_ff[0], s_ff[1], 8))
         ^ (win(s_ff[0], s_ff[1], 13) & win(s_ff[0], s_ff[1], 20))
         ^ (x4 & win(s_ff[1], s_ff[2], 10))
         ^ (win(s_ff[1], s_ff[2], 28) & win(s_ff[2], s_ff[3], 15))
         ^ (x0 & x4 & win(s_ff[2], s_ff[3], 30))
         ^ win(s_ff[2], s_ff[3], 29)
         ^ win(b_ff[0], b_ff[1], 2) ^ win(b_ff[0], b_ff[1], 15)
         ^ win(b_ff[1], b_ff[2], 4) ^ win(b_ff[1], b_ff[2], 13)
         ^ b_ff[2] ^ win(b_ff[2], b_ff[3], 9) ^ win(b_ff[2], b_ff[3], 25);
   end

   // feedback of 32 bit shifts computed as one word
   always_comb begin
      s_fb = s_ff[0] ^ win(s_ff[0], s_ff[1], 7) ^ win(s_ff[1], s_ff[2], 6)
         ^ win(s_ff[2], s_ff[3], 6) ^ win(s_ff[2], s_ff[3], 17) ^ s_ff[3];
      b_fb = s_ff[0] ^ b_ff[0] ^ win(b_ff[0], b_ff[1], 26)
         ^ win(b_ff[1], b_ff[2], 24) ^ win(b_ff[2], b_ff[3], 27) ^ b_ff[3]
         ^ (win(b_ff[0], b_ff[1], 3) & win(b_ff[2], b_ff[3], 3))
         ^ (win(b_ff[0], b_ff[1], 11) & win(b_ff[0], b_ff[1], 13))
         ^ (win(b_ff[0], b_ff[1], 17) & win(b_ff[0], b_ff[1], 18))
         ^ (win(b_ff[0], b_ff[1], 27) & win(b_ff[1], b_ff[2], 27))
         ^ (win(b_ff[1], b_ff[2], 8) & win(b_ff[1], b_ff[2], 16))
         ^ (win(b_ff[1], b_ff[2], 29) & win(b_ff[2], b_ff[3], 1))
         ^ (win(b_ff[2], b_ff[3], 4) & win(b_ff[2], b_ff[3], 20))
         ^ (win(b_ff[0], b_ff[1], 22) & win(b_ff[0], b_ff[1], 24)
            & win(b_ff[0], b_ff[1], 25))
         ^ (win(b_ff[2], b_ff[3], 6) & win(b_ff[2], b_ff[3], 14)
            & win(b_ff[2], b_ff[3], 18))
         ^ (win(b_ff[2], b_ff[3], 24) & win(b_ff[2], b_ff[3], 28)
            & win(b_ff[2], b_ff[3], 29) & win(b_ff[2], b_ff[3], 31));
      unique case (ctl.mode)
         FB_BOTH: begin
            s_fb = s_fb ^ pre_word;
            b_fb = b_fb ^ pre_word;
         end
         FB_LIN:  s_fb = s_fb ^ ctl.lin_extra;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) begin
            s_ff[i] <= '0;
            b_ff[i] <= '0;
         end
      end else if (ctl.load) begin
         for (int i = 0; i < 4; i++) begin
            s_ff[i] <= load_lin[127-32*i -: 32];
            b_ff[i] <= load_nl[127-32*i -: 32];
         end
      end else if (ctl.step) begin
         s_ff[0] <= s_ff[1]; s_ff[1] <= s_ff[2]; s_ff[2] <= s_ff[3]; s_ff[3] <= s_fb;
         b_ff[0] <= b_ff[1]; b_ff[1] <= b_ff[2]; b_ff[2] <= b_ff[3]; b_ff[3] <= b_fb;
      end
   end

endmodule

>>> hdl/gaead_auth.sv
module gaead_auth
   import gaead_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        load_acc,
   input  logic        load_sr,
   input  logic [63:0] load_value,
   input  logic        byte_load,
   input  logic [7:0]  plain_byte,
   input  logic [7:0]  odd_byte,
   input  logic        bit_step,
   input  logic        finish,
   output logic [63:0] acc
);

   logic [63:0] acc_ff, sr_ff;
   logic [7:0]  m_ff, od_ff;

   assign acc = acc_ff;

   // one plaintext bit per clock while bit_step is high, lsb first
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
         sr_ff  <= '0;
      end else if (load_acc) begin
         acc_ff <= load_value;
      end else if (load_sr) begin
         sr_ff <= load_value;
      end else if (finish) begin
         acc_ff <= acc_ff ^ sr_ff;
      end else if (bit_step) begin
         if (m_ff[0]) acc_ff <= acc_ff ^ sr_ff;
         sr_ff <= {sr_ff[62:0], od_ff[0]};
      end
   end

   always_ff @(posedge clock) begin
      if (byte_load) begin
         m_ff  <= plain_byte;
         od_ff <= odd_byte;
      end else if (bit_step) begin
         m_ff  <= {1'b0, m_ff[7:1]};
         od_ff <= {1'b0, od_ff[7:1]};
      end
   end

endmodule

>>> hdl/grain128_aead_byte_engine.sv
// start runs 12 round-unit word steps (8 mixing, 4 key absorb) before its result; a data
//   byte refills the keystream buffer when it is used up, then runs the byte load and 8
//   bit-serial accumulator steps; finish and unused codes go straight to the result
// one word at a time; the next is taken while the result is presented unless it is stalled
// reset (synchronous, active high) clears the state to zero and marks the keystream empty
module grain128_aead_byte_engine
   import gaead_pkg::*;
#(
   parameter int KEYSTREAM_BYTES = 16
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_data
);

   localparam int WORDS = (KEYSTREAM_BYTES + 3) / 4;
   localparam int PW = 5;
   localparam int WW = 2;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_INIT   = 3'd1;
   localparam logic [2:0] ST_FILL   = 3'd2;
   localparam logic [2:0] ST_BYTE   = 3'd3;
   localparam logic [2:0] ST_BITS   = 3'd4;
   localparam logic [2:0] ST_OUT    = 3'd5;

   logic [63:0] key_up_ff, key_lo_ff, non_up_ff;
   logic [31:0] non_lo_ff;
   logic [2:0]  state_ff;
   logic [3:0]  cnt_ff;
   logic [WW-1:0] wcnt_ff;
   logic [PW-1:0] pos_ff;
   logic [7:0]  ks_mem [16];
   req_type     req_ff;
   logic        rsp_valid_ff;
   rsp_type     rsp_ff;
   logic [31:0] acc_hi_ff;
   logic [7:0]  ev_ff, od_ff;

   round_ctl_type ctl;
   logic [31:0] pre_word, iw;
   logic [63:0] acc;
   logic [127:0] load_lin, load_nl;
   logic [7:0]  plain;
   logic        load_acc, load_sr, byte_load, bit_step, fin;
   logic        accept, out_free, is_data;
   logic [31:0] k_word;
   logic [3:0]  wr_idx, rd_idx;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE) || !out_free;
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign is_data   = (req_ff.operation == OP_AUTH) || (req_ff.operation == OP_ENCRYPT)
                      || (req_ff.operation == OP_DECRYPT);

   assign load_lin = {rev_bytes32(non_up_ff[63:32]), rev_bytes32(non_up_ff[31:0]),
                      rev_bytes32(non_lo_ff), PAD_WORD};
   assign load_nl  = {rev_bytes32(key_up_ff[63:32]), rev_bytes32(key_up_ff[31:0]),
                      rev_bytes32(key_lo_ff[63:32]), rev_bytes32(key_lo_ff[31:0])};

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         key_up_ff <= '0; key_lo_ff <= '0; non_up_ff <= '0; non_lo_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_KEY_UPPER:   key_up_ff <= csr_data;
            CSR_KEY_LOWER:   key_lo_ff <= csr_data;
            CSR_NONCE_UPPER: non_up_ff <= csr_data;
            CSR_NONCE_LOWER: non_lo_ff <= csr_data[31:0];
            default: ;
         endcase
      end
   end

   // key word re-absorbed after mixing
   always_comb begin
      unique case (cnt_ff[1:0])
         2'd0:    k_word = load_nl[127:96];
         2'd1:    k_word = load_nl[95:64];
         2'd2:    k_word = load_nl[63:32];
         default: k_word = load_nl[31:0];
      endcase
   end

   assign plain = (req_ff.operation == OP_DECRYPT) ? (req_ff.data_byte ^ ev_ff)
                                                   : req_ff.data_byte;
   assign iw = interleave(pre_word);

   // sequencer controls
   always_comb begin
      ctl = '0;
      load_acc = 1'b0; load_sr = 1'b0; byte_load = 1'b0; bit_step = 1'b0; fin = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            ctl.load = accept && (req_data.operation == OP_START);
            fin = accept && (req_data.operation == OP_FINISH);
         end
         ST_INIT: begin
            ctl.step = 1'b1;
            if (cnt_ff[3] == 1'b0) begin
               ctl.mode = FB_BOTH;
            end else begin
               ctl.mode = FB_LIN;
               ctl.lin_extra = k_word;
               load_acc = (cnt_ff[1:0] == 2'd1);
               load_sr  = (cnt_ff[1:0] == 2'd3);
            end
         end
         ST_FILL: ctl.step = 1'b1;
         ST_BYTE: byte_load = 1'b1;
         ST_BITS: bit_step = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_INIT && cnt_ff[3] && !cnt_ff[0])
         acc_hi_ff <= pre_word;
   end

   assign wr_idx = {wcnt_ff, 2'b00};
   assign rd_idx = pos_ff[3:0] & 4'hE;

   // keystream buffer
   always_ff @(posedge clock) begin
      if (state_ff == ST_FILL) begin
         ks_mem[wr_idx]         <= iw[31:24];
         ks_mem[wr_idx + 4'd1]  <= iw[23:16];
         ks_mem[wr_idx + 4'd2]  <= iw[15:8];
         ks_mem[wr_idx + 4'd3]  <= iw[7:0];
      end
   end

   // state machine
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff <= '0;
         wcnt_ff <= '0;
         pos_ff <= PW'(KEYSTREAM_BYTES);
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: if (accept) begin
               req_ff <= req_data;
               cnt_ff <= '0;
               wcnt_ff <= '0;
               if (req_data.operation == OP_START) begin
                  state_ff <= ST_INIT;
               end else if ((req_data.operation == OP_AUTH)
                            || (req_data.operation == OP_ENCRYPT)
                            || (req_data.operation == OP_DECRYPT)) begin
                  if (pos_ff >= PW'(KEYSTREAM_BYTES) || pos_ff > PW'(14)) state_ff <= ST_FILL;
                  else state_ff <= ST_BYTE;
               end else begin
                  state_ff <= ST_OUT;
               end
            end
            ST_INIT: begin
               cnt_ff <= cnt_ff + 4'd1;
               if (cnt_ff == 4'd11) begin
                  state_ff <= ST_OUT;
                  pos_ff <= PW'(KEYSTREAM_BYTES);
               end
            end
            ST_FILL: begin
               wcnt_ff <= wcnt_ff + WW'(1);
               if (wcnt_ff == WW'(WORDS - 1)) begin
                  state_ff <= ST_BYTE;
                  pos_ff <= '0;
               end
            end
            ST_BYTE: state_ff <= ST_BITS;
            ST_BITS: begin
               cnt_ff <= cnt_ff + 4'd1;
               if (cnt_ff == 4'd7) state_ff <= ST_OUT;
            end
            ST_OUT: begin
               state_ff <= ST_IDLE;
               rsp_valid_ff <= 1'b1;
               rsp_ff <= '0;
               if (req_ff.operation == OP_ENCRYPT) rsp_ff.out_byte <= req_ff.data_byte ^ ev_ff;
               else if (req_ff.operation == OP_DECRYPT) rsp_ff.out_byte <= plain;
               if (req_ff.operation == OP_FINISH) begin
                  rsp_ff.tag_ready <= 1'b1;
                  for (int i = 0; i < 8; i++)
                     for (int j = 0; j < 8; j++)
                        rsp_ff.tag_value[8*i+j] <= acc[8*i+7-j] ^ 1'b0;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
         if (state_ff == ST_BYTE) pos_ff <= pos_ff + PW'(2);
      end
   end

   // keystream pair read: first pair straight from the refill word, else from the buffer
   always_ff @(posedge clock) begin
      if (state_ff == ST_FILL) begin
         if (wcnt_ff == WW'(0)) begin
            ev_ff <= iw[31:24];
            od_ff <= iw[23:16];
         end
      end else if (state_ff == ST_IDLE) begin
         ev_ff <= ks_mem[rd_idx];
         od_ff <= ks_mem[rd_idx + 4'd1];
      end
   end

   gaead_round u_round (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl),
      .load_lin (load_lin),
      .load_nl  (load_nl),
      .pre_word (pre_word)
   );

   gaead_auth u_auth (
      .clock      (clock),
      .reset      (reset),
      .load_acc   (load_acc),
      .load_sr    (load_sr),
      .load_value ({acc_hi_ff, pre_word}),
      .byte_load  (byte_load),
      .plain_byte (plain),
      .odd_byte   (od_ff),
      .bit_step   (bit_step && is_data),
      .finish     (fin),
      .acc        (acc)
   );

endmodule

>>> verif/grain128_aead_byte_engine_tb.sv
`timescale 1ns / 1ps

module grain128_aead_byte_engine_tb;
   import gaead_pkg::*;

   localparam int KS_BYTES = 16;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   rsp_type     rsp_data;
   logic        csr_write;
   logic [1:0]  csr_index;
   logic [63:0] csr_data;

   grain128_aead_byte_engine #(.KEYSTREAM_BYTES(KS_BYTES)) i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   // cipher model state
   logic [63:0] m_key_hi, m_key_lo, m_nonce_hi, m_nonce_lo;
   logic [31:0] m_lfsr [4];
   logic [31:0] m_nfsr [4];
   logic [63:0] m_acc, m_shreg;
   logic [7:0]  m_ks [16];
   int unsigned m_pos;

   rsp_type     pending_rsp [$];
   int          mismatch_count;
   int          rsp_count;
   int          tag_count;
   logic        pass_flag;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #200ms;
      $display("Regression FAIL");
      $finish;
   end

   function automatic logic [31:0] w32(logic [31:0] a, logic [31:0] b, int n);
      logic [63:0] ab;
      ab = {a, b};
      return ab[63-n -: 32];
   endfunction

   function automatic logic [31:0] bitrev8x4(logic [31:0] v);
      logic [31:0] r;
      for (int i = 0; i < 32; i++) r[i] = v[(i & ~7) + 7 - (i & 7)];
      return r;
   endfunction

   function automatic logic [31:0] pre_word();
      logic [31:0] x0, x4, y;
      x0 = w32(m_nfsr[0], m_nfsr[1], 12);
      x4 = w32(m_nfsr[2], m_nfsr[3], 31);
      y  = x0 & w32(m_lfsr[0], m_lfsr[1], 8);
      y ^= w32(m_lfsr[0], m_lfsr[1], 13) & w32(m_lfsr[0], m_lfsr[1], 20);
      y ^= x4 & w32(m_lfsr[1], m_lfsr[2], 10);
      y ^= w32(m_lfsr[1], m_lfsr[2], 28) & w32(m_lfsr[2], m_lfsr[3], 15);
      y ^= x0 & x4 & w32(m_lfsr[2], m_lfsr[3], 30);
      y ^= w32(m_lfsr[2], m_lfsr[3], 29);
      y ^= w32(m_nfsr[0], m_nfsr[1], 2) ^ w32(m_nfsr[0], m_nfsr[1], 15);
      y ^= w32(m_nfsr[1], m_nfsr[2], 4) ^ w32(m_nfsr[1], m_nfsr[2], 13);
      y ^= m_nfsr[2] ^ w32(m_nfsr[2], m_nfsr[3], 9) ^ w32(m_nfsr[2], m_nfsr[3], 25);
      return y;
   endfunction

   // one word (32 bit shifts) of both registers
   task automatic clock_word(logic [31:0] lin_in, logic [31:0] nl_in);
      logic [31:0] s0, s1, s2, s3, b0, b1, b2, b3, x, x2;
      s0 = m_lfsr[0]; s1 = m_lfsr[1]; s2 = m_lfsr[2]; s3 = m_lfsr[3];
      b0 = m_nfsr[0]; b1 = m_nfsr[1]; b2 = m_nfsr[2]; b3 = m_nfsr[3];
      x = lin_in ^ s0 ^ w32(s0, s1, 7) ^ w32(s1, s2, 6) ^ w32(s2, s3, 6)
          ^ w32(s2, s3, 17) ^ s3;
      x2 = nl_in ^ s0 ^ b0 ^ w32(b0, b1, 26) ^ w32(b1, b2, 24) ^ w32(b2, b3, 27) ^ b3;
      x2 ^= w32(b0, b1, 3) & w32(b2, b3, 3);
      x2 ^= w32(b0, b1, 11) & w32(b0, b1, 13);
      x2 ^= w32(b0, b1, 17) & w32(b0, b1, 18);
      x2 ^= w32(b0, b1, 27) & w32(b1, b2, 27);
      x2 ^= w32(b1, b2, 8) & w32(b1, b2, 16);
      x2 ^= w32(b1, b2, 29) & w32(b2, b3, 1);
      x2 ^= w32(b2, b3, 4) & w32(b2, b3, 20);
      x2 ^= w32(b0, b1, 22) & w32(b0, b1, 24) & w32(b0, b1, 25);
      x2 ^= w32(b2, b3, 6) & w32(b2, b3, 14) & w32(b2, b3, 18);
      x2 ^= w32(b2, b3, 24) & w32(b2, b3, 28) & w32(b2, b3, 29) & w32(b2, b3, 31);
      m_lfsr[0] = s1; m_lfsr[1] = s2; m_lfsr[2] = s3; m_lfsr[3] = x;
      m_nfsr[0] = b1; m_nfsr[1] = b2; m_nfsr[2] = b3; m_nfsr[3] = x2;
   endtask

   function automatic logic [31:0] swp(logic [31:0] v, logic [31:0] m, int s);
      logic [31:0] t;
      t = ((v >> s) ^ v) & m;
      return v ^ t ^ (t << s);
   endfunction

   task automatic refill_keystream();
      logic [31:0] x;
      for (int p = 0; p < KS_BYTES && p + 4 <= 16; p += 4) begin
         x = pre_word();
         clock_word(32'h0, 32'h0);
         x = swp(x, 32'h11111111, 3);
         x = swp(x, 32'h03030303, 6);
         x = swp(x, 32'h000f000f, 12);
         x = ((x & 32'h00ff00ff) << 8) | ((x >> 8) & 32'h00ff00ff);
         m_ks[p] = x[31:24]; m_ks[p+1] = x[23:16];
         m_ks[p+2] = x[15:8]; m_ks[p+3] = x[7:0];
      end
   endtask

   task automatic load_session();
      logic [31:0] k [4];
      m_lfsr[0] = bitrev8x4(m_nonce_hi[63:32]);
      m_lfsr[1] = bitrev8x4(m_nonce_hi[31:0]);
      m_lfsr[2] = bitrev8x4(m_nonce_lo[31:0]);
      m_lfsr[3] = PAD_WORD;
      k[0] = bitrev8x4(m_key_hi[63:32]); k[1] = bitrev8x4(m_key_hi[31:0]);
      k[2] = bitrev8x4(m_key_lo[63:32]); k[3] = bitrev8x4(m_key_lo[31:0]);
      for (int i = 0; i < 4; i++) m_nfsr[i] = k[i];
      for (int r = 0; r < 8; r++) begin
         logic [31:0] y;
         y = pre_word();
         clock_word(y, y);
      end
      m_acc[63:32] = pre_word();   clock_word(k[0], 32'h0);
      m_acc[31:0] = pre_word();    clock_word(k[1], 32'h0);
      m_shreg[63:32] = pre_word(); clock_word(k[2], 32'h0);
      m_shreg[31:0] = pre_word();  clock_word(k[3], 32'h0);
      m_pos = KS_BYTES;
   endtask

   // consume one keystream pair, authenticate the plaintext, return even byte
   task automatic absorb_byte(logic [7:0] plain, output logic [7:0] ev);
      logic [7:0] od;
      if (m_pos >= KS_BYTES || m_pos > 14) begin
         refill_keystream();
         m_pos = 0;
      end
      ev = m_ks[m_pos & 15];
      od = m_ks[(m_pos + 1) & 15];
      m_pos = (m_pos + 2) & 31;
      for (int i = 0; i < 8; i++) begin
         if (plain[i]) m_acc ^= m_shreg;
         m_shreg = {m_shreg[62:0], od[i]};
      end
   endtask

   task automatic predict_word(req_type rq, output rsp_type rs);
      logic [7:0]  ev;
      logic [63:0] t;
      rs = '0;
      case (rq.operation)
         OP_START: begin
            load_session();
         end
         OP_AUTH: begin
            absorb_byte(rq.data_byte, ev);
         end
         OP_ENCRYPT: begin
            absorb_byte(rq.data_byte, ev);
            rs.out_byte = rq.data_byte ^ ev;
         end
         OP_DECRYPT: begin
            // keystream byte is needed before the plaintext is known
            if (m_pos >= KS_BYTES || m_pos > 14) begin
               refill_keystream();
               m_pos = 0;
            end
            rs.out_byte = rq.data_byte ^ m_ks[m_pos & 15];
            absorb_byte(rs.out_byte, ev);
         end
         OP_FINISH: begin
            m_acc ^= m_shreg;
            for (int i = 0; i < 64; i++) t[i] = m_acc[(i & ~7) + 7 - (i & 7)];
            rs.tag_value = t;
            rs.tag_ready = 1'b1;
         end
         default: begin
         end
      endcase
   endtask

   // response checker and stall generator
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            rsp_count++;
            if (pending_rsp.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected response word %h", rsp_data);
            end else begin
               want = pending_rsp.pop_front();
               if (rsp_data.out_byte !== want.out_byte ||
                   rsp_data.tag_value !== want.tag_value ||
                   rsp_data.tag_ready !== want.tag_ready) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("mismatch: exp out=%h tag=%h rdy=%b got out=%h tag=%h rdy=%b",
                              want.out_byte, want.tag_value, want.tag_ready,
                              rsp_data.out_byte, rsp_data.tag_value, rsp_data.tag_ready);
               end
               if (want.tag_ready) tag_count++;
            end
         end
         if ($urandom_range(0, 3) == 0) rsp_stall <= ($urandom_range(0, 9) == 0) ?
               ($urandom_range(0, 1) == 1) : 1'b1;
         else rsp_stall <= 1'b0;
      end
   end

   task automatic idle_gap();
      int n;
      n = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
      if ($urandom_range(0, 2) == 0) n = 0;
      repeat (n) @(posedge clock);
   endtask

   // send one request word and record its prediction
   task automatic send_word(req_type rq);
      rsp_type rs;
      logic    stalled;
      req_valid <= 1'b1;
      req_data  <= rq;
      // stall is sampled between edges so the accepting edge is seen exactly once
      forever begin
         @(negedge clock);
         stalled = req_stall;
         @(posedge clock);
         if (!stalled) break;
      end
      predict_word(rq, rs);
      pending_rsp.push_back(rs);
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   // check a table row's known result against the model too
   task automatic send_known(req_type rq, rsp_type known);
      rsp_type rs;
      rs = pending_rsp.size() == 0 ? '0 : '0;
      send_word(rq);
      rs = pending_rsp[$];
      if (rs !== known) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("table row %h: model %h, table %h", rq, rs, known);
      end
   endtask

   task automatic drain();
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [63:0] val);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      csr_write <= 1'b0;
      case (idx)
         CSR_KEY_UPPER:   m_key_hi = val;
         CSR_KEY_LOWER:   m_key_lo = val;
         CSR_NONCE_UPPER: m_nonce_hi = val;
         default:         m_nonce_lo = {32'h0, val[31:0]};
      endcase
      @(posedge clock);
   endtask

   task automatic program_session(int mode);
      logic [63:0] v [4];
      for (int i = 0; i < 4; i++) begin
         case (mode)
            0: v[i] = '0;
            1: v[i] = '1;
            default: v[i] = {$urandom, $urandom};
         endcase
      end
      write_reg(CSR_KEY_UPPER, v[0]);
      write_reg(CSR_KEY_LOWER, v[1]);
      write_reg(CSR_NONCE_UPPER, v[2]);
      write_reg(CSR_NONCE_LOWER, v[3]);
   endtask

   typedef struct {
      req_type rq;
      logic    known;
      rsp_type rs;
   } table_row_type;

   table_row_type dir_table [$];
   req_type       rq;
   int            sent;
   int            msg_len;
   logic [2:0]    op_pick;

   initial begin
      m_key_hi = '0; m_key_lo = '0; m_nonce_hi = '0; m_nonce_lo = '0;
      for (int i = 0; i < 4; i++) begin m_lfsr[i] = '0; m_nfsr[i] = '0; end
      for (int i = 0; i < 16; i++) m_ks[i] = '0;
      m_acc = '0; m_shreg = '0; m_pos = KS_BYTES;
      mismatch_count = 0; rsp_count = 0; tag_count = 0; sent = 0;
      reset = 1'b1; req_valid = 1'b0; req_data = '0;
      csr_write = 1'b0; csr_index = '0; csr_data = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: operations before any start, unused codes, extremes
      dir_table.push_back('{'{OP_FINISH, 8'h00}, 1'b1, '{8'h00, 64'h0, 1'b1}});
      dir_table.push_back('{'{3'd5, 8'hFF}, 1'b1, '{8'h00, 64'h0, 1'b0}});
      dir_table.push_back('{'{3'd7, 8'h5A}, 1'b1, '{8'h00, 64'h0, 1'b0}});
      dir_table.push_back('{'{3'd6, 8'h00}, 1'b1, '{8'h00, 64'h0, 1'b0}});
      dir_table.push_back('{'{OP_AUTH, 8'hFF}, 1'b0, '0});
      dir_table.push_back('{'{OP_ENCRYPT, 8'h00}, 1'b0, '0});
      dir_table.push_back('{'{OP_START, 8'hA5}, 1'b1, '{8'h00, 64'h0, 1'b0}});
      dir_table.push_back('{'{OP_AUTH, 8'h00}, 1'b0, '0});
      dir_table.push_back('{'{OP_AUTH, 8'hFF}, 1'b0, '0});
      for (int i = 0; i < 9; i++)
         dir_table.push_back('{'{OP_ENCRYPT, (i[0] ? 8'hFF : 8'h00)}, 1'b0, '0});
      dir_table.push_back('{'{OP_DECRYPT, 8'hFF}, 1'b0, '0});
      dir_table.push_back('{'{OP_DECRYPT, 8'h00}, 1'b0, '0});
      dir_table.push_back('{'{OP_FINISH, 8'hFF}, 1'b0, '0});
      dir_table.push_back('{'{OP_FINISH, 8'h00}, 1'b0, '0});

      for (int mode = 0; mode < 3; mode++) begin
         program_session(mode);
         foreach (dir_table[i]) begin
            if (dir_table[i].known && mode == 0) send_known(dir_table[i].rq, dir_table[i].rs);
            else send_word(dir_table[i].rq);
            sent++;
            idle_gap();
         end
         drain();
      end

      // random sessions: mostly well-formed messages, some noise
      while (sent < 1850) begin
         drain();
         program_session($urandom_range(0, 9) == 0 ? $urandom_range(0, 1) : 2);
         if ($urandom_range(0, 7) != 0) begin
            send_word('{OP_START, 8'($urandom)});
            sent++;
         end
         msg_len = $urandom_range(0, 9) == 0 ? $urandom_range(20, 60) : $urandom_range(0, 12);
         for (int i = 0; i < msg_len; i++) begin
            op_pick = $urandom_range(0, 19) == 0 ? 3'($urandom) :
                      3'(OP_AUTH + $urandom_range(0, 2));
            send_word('{op_pick, 8'($urandom)});
            sent++;
            idle_gap();
         end
         send_word('{OP_FINISH, 8'($urandom)});
         sent++;
         if ($urandom_range(0, 5) == 0) begin
            send_word('{OP_FINISH, 8'($urandom)});
            sent++;
         end
         if ($urandom_range(0, 9) == 0) begin
            // hold the sender until the engine has emptied out
            while (pending_rsp.size() != 0) @(posedge clock);
         end
         idle_gap();
      end

      drain();
      $display("covered %0d request words, %0d responses, %0d tags", sent, rsp_count,
               tag_count);
      $display("sessions used zero, all-ones and random keys and nonces");
      pass_flag = (mismatch_count == 0) && (pending_rsp.size() == 0);
      if (pass_flag) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

endmodule

>>> filelist.f
hdl/gaead_pkg.sv
hdl/gaead_round.sv
hdl/gaead_auth.sv
hdl/grain128_aead_byte_engine.sv
verif/grain128_aead_byte_engine_tb.sv
